/* hdl/wlrr_pkg.sv */
// Shared types and constants for the wear-leveled record ring.
// Holds the beat structs, operation and register codes, and store geometry.
// No dependencies.
`timescale 1ns / 1ps

package wlrr_pkg;

    localparam int MAX_BLOCKS = 8;
    localparam int MAX_SLOTS  = 32;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int ADDR_W     = BLK_W + SLOT_W;
    localparam int DEPTH      = MAX_BLOCKS * MAX_SLOTS;
    localparam int PAY_W      = 32;
    localparam int SEQ_W      = 8;

    localparam logic [SEQ_W-1:0] SEQ_LIMIT = 8'd251;
    localparam logic [SEQ_W-1:0] ERASED    = 8'hFF;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_MOUNT = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic [1:0] REG_BLOCKS = 2'd0;
    localparam logic [1:0] REG_SLOTS  = 2'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  newest_block;
        logic [4:0]  newest_slot;
        logic [1:0]  size_errors;
        logic        store_cleared;
    } rsp_t;

endpackage

/* hdl/wear_leveled_record_ring_core.sv */
// Wear-leveled record ring: sequencer around one slot memory and a header file.
// Depends on wlrr_pkg.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | wlrr_pkg::req_t (kind, payload)
//  rsp     | out | rsp_valid/rsp_ready   | wlrr_pkg::rsp_t
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A read or write passes S_DEC and then S_OUT; a write that rolls to the next block also passes S_WROLL.
// Mount runs the header walk over the header file and then the slot walk
// through the single read port of the slot memory.
// Reset marks every slot erased at once through per-entry valid bits; no sweep.
// A waiting result does not block the next accept; a new result waits for the output register.
`timescale 1ns / 1ps

module wear_leveled_record_ring_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  wlrr_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output wlrr_pkg::rsp_t  rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DEC   = 11'b000_0000_0010,
        S_WROLL = 11'b000_0000_0100,
        S_MCHK  = 11'b000_0000_1000,
        S_MWALK = 11'b000_0001_0000,
        S_RD0   = 11'b000_0010_0000,
        S_RD1   = 11'b000_0100_0000,
        S_RCHK  = 11'b000_1000_0000,
        S_SWALK = 11'b001_0000_0000,
        S_FETCH = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    localparam int BW = wlrr_pkg::BLK_W;
    localparam int SW = wlrr_pkg::SLOT_W;
    localparam int AW = wlrr_pkg::ADDR_W;
    localparam int QW = wlrr_pkg::SEQ_W;
    localparam int PW = wlrr_pkg::PAY_W;
    localparam int WW = QW + PW;

    function automatic logic [QW-1:0] seq_inc(input logic [QW-1:0] v);
        logic [QW:0] s;
        s = {1'b0, v} + 1'b1;
        return (s > {1'b0, wlrr_pkg::SEQ_LIMIT}) ? '0 : s[QW-1:0];
    endfunction

    function automatic logic is_next(input logic [QW-1:0] prev, input logic [QW-1:0] v);
        return ({1'b0, v} == ({1'b0, prev} + 1'b1));
    endfunction

    state_t                state_reg, state_next;
    wlrr_pkg::req_t        item_reg, item_next;
    logic [3:0]            blocks_reg;
    logic [5:0]            slots_reg;
    logic [BW-1:0]         cur_blk_reg, cur_blk_next;
    logic [QW-1:0]         cur_bcnt_reg, cur_bcnt_next;
    logic [SW-1:0]         cur_slot_reg, cur_slot_next;
    logic [QW-1:0]         cur_dcnt_reg, cur_dcnt_next;
    logic [QW-1:0]         hdr_reg [wlrr_pkg::MAX_BLOCKS];
    logic [QW-1:0]         hdr_next [wlrr_pkg::MAX_BLOCKS];
    logic [QW-1:0]         first_reg, first_next;
    logic [QW-1:0]         prev_reg, prev_next;
    logic [5:0]            idx_reg, idx_next;
    logic                  cleared_reg, cleared_next;
    logic                  from_mem_reg, from_mem_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    wlrr_pkg::rsp_t        rsp_reg, rsp_next;
    logic [wlrr_pkg::DEPTH-1:0] vld_reg, vld_next;

    logic [WW-1:0]         seq_mem [wlrr_pkg::DEPTH];
    logic [WW-1:0]         rd_word_reg;
    logic                  rd_hit_reg;

    logic                  mem_we, mem_re, erase_all;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [WW-1:0]         mem_wdata;
    logic [wlrr_pkg::MAX_BLOCKS-1:0] row_clr;

    logic [3:0]            nb;
    logic [5:0]            ns;
    logic [5:0]            ns_m1;
    logic [3:0]            nb_m1;
    logic [9:0]            area;
    logic [QW-1:0]         seq_q;
    logic [PW-1:0]         pay_q;
    logic [QW-1:0]         first_v, last_v, hv, dv;
    logic [9:0]            span;
    logic                  ok, roll;
    logic [BW:0]           nblk_w;
    logic [BW-1:0]         nblk;
    logic [5:0]            idx_inc;

    assign nb = (blocks_reg == 4'd0) ? 4'd1 :
                (blocks_reg > 4'(wlrr_pkg::MAX_BLOCKS)) ? 4'(wlrr_pkg::MAX_BLOCKS) : blocks_reg;
    assign ns = (slots_reg < 6'd2) ? 6'd2 :
                (slots_reg > 6'(wlrr_pkg::MAX_SLOTS)) ? 6'(wlrr_pkg::MAX_SLOTS) : slots_reg;
    assign ns_m1 = ns - 6'd1;
    assign nb_m1 = nb - 4'd1;
    assign area  = {6'd0, nb} * {4'd0, ns};
    assign seq_q = rd_hit_reg ? rd_word_reg[WW-1:PW] : wlrr_pkg::ERASED;
    assign pay_q = rd_hit_reg ? rd_word_reg[PW-1:0] : '1;
    assign idx_inc = idx_reg + 6'd1;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cur_blk_next   = cur_blk_reg;
        cur_bcnt_next  = cur_bcnt_reg;
        cur_slot_next  = cur_slot_reg;
        cur_dcnt_next  = cur_dcnt_reg;
        hdr_next       = hdr_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        cleared_next   = cleared_reg;
        from_mem_next  = from_mem_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        vld_next       = vld_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        erase_all      = 1'b0;
        row_clr        = '0;
        first_v        = '0;
        last_v         = '0;
        hv             = '0;
        dv             = '0;
        span           = '0;
        ok             = 1'b0;
        roll           = 1'b0;
        nblk_w         = '0;
        nblk           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cleared_next  = 1'b0;
                from_mem_next = 1'b0;
                if (item_reg.kind == wlrr_pkg::KIND_WRITE)
                begin
                    roll = ({1'b0, cur_slot_reg} >= ns_m1);
                    if (roll)
                    begin
                        nblk_w = {1'b0, cur_blk_reg} + 1'b1;
                        nblk   = (nblk_w >= nb) ? '0 : nblk_w[BW-1:0];
                        dv     = seq_inc(cur_bcnt_reg);
                        hdr_next[nblk] = dv;
                        cur_blk_next   = nblk;
                        cur_bcnt_next  = dv;
                        cur_slot_next  = '0;
                        mem_re         = 1'b1;
                        mem_raddr      = {nblk, ns_m1[SW-1:0]};
                        state_next     = S_WROLL;
                    end
                    else
                    begin
                        if (cur_dcnt_reg > wlrr_pkg::SEQ_LIMIT)
                        begin
                            dv        = '0;
                            mem_waddr = {cur_blk_reg, cur_slot_reg};
                        end
                        else
                        begin
                            dv            = seq_inc(cur_dcnt_reg);
                            cur_slot_next = cur_slot_reg + 1'b1;
                            mem_waddr     = {cur_blk_reg, cur_slot_reg + 1'b1};
                        end
                        cur_dcnt_next = dv;
                        mem_we        = 1'b1;
                        mem_wdata     = {dv, item_reg.payload};
                        state_next    = S_OUT;
                    end
                end
                else if (item_reg.kind == wlrr_pkg::KIND_MOUNT)
                begin
                    if (hdr_reg[0] == wlrr_pkg::ERASED)
                    begin
                        erase_all    = 1'b1;
                        cleared_next = 1'b1;
                    end
                    state_next = S_MCHK;
                end
                else
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = {cur_blk_reg, cur_slot_reg};
                    from_mem_next = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_WROLL:
            begin
                dv = (seq_q > wlrr_pkg::SEQ_LIMIT) ? '0 : seq_inc(seq_q);
                cur_dcnt_next = dv;
                mem_we        = 1'b1;
                mem_waddr     = {cur_blk_reg, {SW{1'b0}}};
                mem_wdata     = {dv, item_reg.payload};
                state_next    = S_OUT;
            end
            S_MCHK:
            begin
                first_v = hdr_reg[0];
                last_v  = hdr_reg[nb_m1[BW-1:0]];
                span    = {2'd0, first_v} + {6'd0, nb} - 10'd1;
                if (last_v >= wlrr_pkg::SEQ_LIMIT)
                    ok = (first_v == '0) || (first_v == wlrr_pkg::ERASED);
                else
                    ok = is_next(last_v, first_v) || ({2'd0, last_v} == span);
                if (!ok)
                begin
                    erase_all    = 1'b1;
                    cleared_next = 1'b1;
                    state_next   = S_RD0;
                end
                else
                begin
                    prev_next    = first_v;
                    cur_blk_next = '0;
                    idx_next     = 6'd1;
                    if (nb == 4'd1)
                    begin
                        cur_bcnt_next = first_v;
                        state_next    = S_RD0;
                    end
                    else
                    begin
                        state_next = S_MWALK;
                    end
                end
            end
            S_MWALK:
            begin
                hv = hdr_reg[idx_reg[BW-1:0]];
                if (is_next(prev_reg, hv))
                begin
                    prev_next    = hv;
                    cur_blk_next = idx_reg[BW-1:0];
                    if (idx_inc >= {2'd0, nb})
                    begin
                        cur_bcnt_next = hv;
                        state_next    = S_RD0;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                else
                begin
                    cur_bcnt_next = prev_reg;
                    state_next    = S_RD0;
                end
            end
            S_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {cur_blk_reg, {SW{1'b0}}};
                state_next = S_RD1;
            end
            S_RD1:
            begin
                first_next = seq_q;
                mem_re     = 1'b1;
                mem_raddr  = {cur_blk_reg, ns_m1[SW-1:0]};
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                last_v = seq_q;
                span   = {2'd0, first_reg} + {4'd0, ns} - 10'd1;
                if (last_v >= wlrr_pkg::SEQ_LIMIT)
                    ok = (first_reg == '0) || (first_reg > wlrr_pkg::SEQ_LIMIT);
                else
                    ok = is_next(last_v, first_reg) || ({2'd0, last_v} == span);
                cur_slot_next = '0;
                if (!ok)
                begin
                    row_clr[cur_blk_reg] = 1'b1;
                    cur_dcnt_next = wlrr_pkg::ERASED;
                    cleared_next  = 1'b1;
                    state_next    = S_FETCH;
                end
                else
                begin
                    prev_next = first_reg;
                    if (first_reg == wlrr_pkg::SEQ_LIMIT)
                    begin
                        cur_dcnt_next = first_reg;
                        state_next    = S_FETCH;
                    end
                    else
                    begin
                        idx_next   = 6'd1;
                        mem_re     = 1'b1;
                        mem_raddr  = {cur_blk_reg, SW'(1)};
                        state_next = S_SWALK;
                    end
                end
            end
            S_SWALK:
            begin
                if (is_next(prev_reg, seq_q))
                begin
                    prev_next     = seq_q;
                    cur_slot_next = idx_reg[SW-1:0];
                    if (idx_inc >= ns)
                    begin
                        cur_dcnt_next = seq_q;
                        state_next    = S_FETCH;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        mem_re    = 1'b1;
                        mem_raddr = {cur_blk_reg, idx_inc[SW-1:0]};
                    end
                end
                else
                begin
                    cur_dcnt_next = prev_reg;
                    state_next    = S_FETCH;
                end
            end
            S_FETCH:
            begin
                mem_re        = 1'b1;
                mem_raddr     = {cur_blk_reg, cur_slot_reg};
                from_mem_next = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.read_data      = from_mem_reg ? pay_q : item_reg.payload;
                    rsp_next.newest_block   = 3'(cur_blk_reg);
                    rsp_next.newest_slot    = 5'(cur_slot_reg);
                    rsp_next.size_errors[0] = ({2'd0, ns} >= wlrr_pkg::SEQ_LIMIT);
                    rsp_next.size_errors[1] = (area >= 10'(wlrr_pkg::SEQ_LIMIT));
                    rsp_next.store_cleared  = cleared_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (erase_all)
        begin
            for (int b = 0; b < wlrr_pkg::MAX_BLOCKS; b++)
            begin
                if (4'(b) < nb)
                begin
                    hdr_next[b] = wlrr_pkg::ERASED;
                    row_clr[b]  = 1'b1;
                end
            end
            hdr_next[0]   = '0;
            cur_blk_next  = '0;
            cur_bcnt_next = '0;
            cur_slot_next = '0;
            cur_dcnt_next = wlrr_pkg::ERASED;
        end

        for (int r = 0; r < wlrr_pkg::MAX_BLOCKS; r++)
        begin
            if (row_clr[r])
                vld_next[r*wlrr_pkg::MAX_SLOTS +: wlrr_pkg::MAX_SLOTS] = '0;
        end
        if (mem_we)
            vld_next[mem_waddr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            blocks_reg    <= 4'd8;
            slots_reg     <= 6'd16;
            cur_blk_reg   <= '0;
            cur_bcnt_reg  <= '0;
            cur_slot_reg  <= '0;
            cur_dcnt_reg  <= wlrr_pkg::ERASED;
            for (int b = 0; b < wlrr_pkg::MAX_BLOCKS; b++)
                hdr_reg[b] <= wlrr_pkg::ERASED;
            cleared_reg   <= 1'b0;
            from_mem_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_blk_reg   <= cur_blk_next;
            cur_bcnt_reg  <= cur_bcnt_next;
            cur_slot_reg  <= cur_slot_next;
            cur_dcnt_reg  <= cur_dcnt_next;
            hdr_reg       <= hdr_next;
            cleared_reg   <= cleared_next;
            from_mem_reg  <= from_mem_next;
            rsp_valid_reg <= rsp_valid_next;
            vld_reg       <= vld_next;
            if (cfg_valid && cfg_index == wlrr_pkg::REG_BLOCKS)
                blocks_reg <= cfg_data[3:0];
            if (cfg_valid && cfg_index == wlrr_pkg::REG_SLOTS)
                slots_reg <= cfg_data[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        first_reg <= first_next;
        prev_reg  <= prev_next;
        idx_reg   <= idx_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            seq_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_word_reg <= seq_mem[mem_raddr];
            rd_hit_reg  <= vld_reg[mem_raddr];
        end
    end

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("accept while an item is in flight");

    a_clear_only_mount: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && cleared_reg |-> item_reg.kind == wlrr_pkg::KIND_MOUNT)
        else $error("cleared flag outside a mount");

    a_roll_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WROLL |=> cur_slot_reg == '0)
        else $error("rolled write not at slot zero");

    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && (row_clr != '0)))
        else $error("slot write collides with erase");

endmodule
